@@ rtl/mrte_pkg.sv @@
// Shared types and constants for the meter register time extractor.
package mrte_pkg;

    // Value capture buffer and identifier sizes
    localparam int VALUE_CHARS = 8;
    localparam int ID_CHARS    = 8;
    localparam int ValueIdxW   = $clog2(VALUE_CHARS);
    localparam int CountW      = $clog2(VALUE_CHARS + 1);
    localparam int IdPosW      = $clog2(ID_CHARS + 1);
    localparam int IdIdxW      = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;

    // Configuration port
    localparam int CfgDataW = 64;
    localparam int CfgIdxW  = 1;
    localparam logic [CfgIdxW-1:0] REG_ID     = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_ID_LEN = 1'd1;
    localparam logic [63:0] ID_RESET     = 64'd211228896816;
    localparam logic [3:0]  ID_LEN_RESET = 4'd5;

    // Item kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // Characters
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [VALUE_CHARS-1:0][7:0] t_value_store;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic       time_updated;
    } t_out;

    // Decoded time from the capture buffer
    typedef struct packed {
        logic       valid;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } t_time;

endpackage

@@ rtl/meter_register_time_extractor_core.sv @@
// Meter register time extractor: finds a register identifier in a meter
// reply, captures its value and decodes the time. One item is taken per clock
// cycle; every reply byte is fully handled in the cycle it is transferred.
// End items (reply complete or timed out) produce one result, held in an
// output register; reply bytes keep flowing while that result waits, and only
// a following end item is held off while the output register is occupied and
// stalled. The result is registered and appears in the cycle after the end item's transfer.
module meter_register_time_extractor_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [mrte_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [mrte_pkg::CfgDataW-1:0]   i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mrte_pkg::t_in                   i_in,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mrte_pkg::t_out                  o_out
);

    // Configuration registers
    logic [63:0] r_id;
    logic [3:0]  r_id_len;

    // Parse state
    logic [mrte_pkg::IdPosW-1:0] r_match, n_match;
    logic                        r_await, n_await;
    logic                        r_capt, n_capt;
    logic                        r_found, n_found;
    mrte_pkg::t_value_store      r_store, n_store;
    logic [mrte_pkg::CountW-1:0] r_count, n_count;
    logic [6:0]                  r_hour, n_hour;
    logic [6:0]                  r_min, n_min;
    logic [6:0]                  r_sec, n_sec;

    // Output register
    logic            r_out_valid, n_out_valid;
    mrte_pkg::t_out  r_out, n_out;

    logic                        w_end;
    logic                        w_take;
    logic [mrte_pkg::IdPosW-1:0] w_len;
    logic [7:0]                  w_id_ch;
    logic [7:0]                  w_id0;
    logic [7:0]                  w_b;
    mrte_pkg::t_time             w_time;

    mrte_time_decode u_decode (
        .i_store (r_store),
        .i_count (r_count),
        .o_time  (w_time)
    );

    assign w_end = (i_in.kind == mrte_pkg::KIND_DONE)
                || (i_in.kind == mrte_pkg::KIND_TIMEOUT);
    // end items wait only while a result is held and stalled
    assign o_in_stall = r_out_valid && i_out_stall && w_end;
    assign w_take     = i_in_valid && !o_in_stall;
    assign w_b        = i_in.data_byte;

    // Effective identifier length, clamped to 1..ID_CHARS
    always_comb begin
        if (r_id_len == 4'd0) begin
            w_len = mrte_pkg::IdPosW'(1);
        end else if (r_id_len > 4'(mrte_pkg::ID_CHARS)) begin
            w_len = mrte_pkg::IdPosW'(mrte_pkg::ID_CHARS);
        end else begin
            w_len = mrte_pkg::IdPosW'(r_id_len);
        end
    end

    assign w_id0   = r_id[7:0];
    assign w_id_ch = r_id[8 * r_match[mrte_pkg::IdIdxW-1:0] +: 8];

    // Per-item next state
    always_comb begin
        n_match     = r_match;
        n_await     = r_await;
        n_capt      = r_capt;
        n_found     = r_found;
        n_store     = r_store;
        n_count     = r_count;
        n_hour      = r_hour;
        n_min       = r_min;
        n_sec       = r_sec;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (w_take) begin
            case (i_in.kind)
                mrte_pkg::KIND_BYTE: begin
                    if (r_found) begin
                        // capture value characters
                        if (r_capt) begin
                            if (w_b == mrte_pkg::CH_CLOSE || w_b == mrte_pkg::CH_STAR) begin
                                n_capt = 1'b0;
                            end else if (r_count < mrte_pkg::CountW'(mrte_pkg::VALUE_CHARS)) begin
                                n_store[r_count[mrte_pkg::ValueIdxW-1:0]] = w_b;
                                n_count = r_count + 1'b1;
                            end
                        end
                    end else if (r_await || !(r_match < w_len && w_b == w_id_ch)) begin
                        if (r_await && w_b == mrte_pkg::CH_OPEN) begin
                            n_await = 1'b0;
                            n_found = 1'b1;
                            n_capt  = 1'b1;
                            n_count = '0;
                        end else begin
                            // recheck byte as a possible first identifier char
                            n_await = (w_b == w_id0) && (w_len == mrte_pkg::IdPosW'(1));
                            n_match = ((w_b == w_id0) && !n_await)
                                    ? mrte_pkg::IdPosW'(1) : '0;
                        end
                    end else begin
                        // identifier char matched
                        if (r_match + 1'b1 == w_len) begin
                            n_match = '0;
                            n_await = 1'b1;
                        end else begin
                            n_match = r_match + 1'b1;
                        end
                    end
                end
                mrte_pkg::KIND_DONE, mrte_pkg::KIND_TIMEOUT: begin
                    n_out.time_updated = 1'b0;
                    if (i_in.kind == mrte_pkg::KIND_DONE && r_found && w_time.valid) begin
                        n_hour = w_time.hour;
                        n_min  = w_time.minute;
                        n_sec  = w_time.second;
                        n_out.time_updated = 1'b1;
                    end
                    n_out.hour   = n_hour;
                    n_out.minute = n_min;
                    n_out.second = n_sec;
                    n_out_valid  = 1'b1;
                    // clear parse state for the next reply
                    n_match = '0;
                    n_await = 1'b0;
                    n_capt  = 1'b0;
                    n_found = 1'b0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id        <= mrte_pkg::ID_RESET;
            r_id_len    <= mrte_pkg::ID_LEN_RESET;
            r_match     <= '0;
            r_await     <= 1'b0;
            r_capt      <= 1'b0;
            r_found     <= 1'b0;
            r_count     <= '0;
            r_hour      <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mrte_pkg::REG_ID:     r_id     <= i_cfg_data;
                    mrte_pkg::REG_ID_LEN: r_id_len <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            r_match     <= n_match;
            r_await     <= n_await;
            r_capt      <= n_capt;
            r_found     <= n_found;
            r_count     <= n_count;
            r_hour      <= n_hour;
            r_min       <= n_min;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ rtl/mrte_time_decode.sv @@
// Decodes hh?mm?ss from the captured value characters.
module mrte_time_decode (
    input  mrte_pkg::t_value_store       i_store,
    input  logic [mrte_pkg::CountW-1:0]  i_count,
    output mrte_pkg::t_time              o_time
);

    logic [5:0]      w_ok;
    logic [5:0][3:0] w_dig;
    logic [6:0]      w_pair [3];

    // Digit checks at positions 0,1 / 3,4 / 6,7
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            automatic logic [mrte_pkg::ValueIdxW-1:0] p =
                mrte_pkg::ValueIdxW'((k / 2) * 3 + (k % 2));
            w_ok[k]  = (mrte_pkg::CountW'(p) < i_count)
                    && (i_store[p] >= mrte_pkg::CH_ZERO)
                    && (i_store[p] <= mrte_pkg::CH_NINE);
            w_dig[k] = 4'(i_store[p] - mrte_pkg::CH_ZERO);
        end
    end

    // tens * 10 + units, as shifts and adds
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_pair[j] = {w_dig[2*j], 3'b000} + {2'b00, w_dig[2*j], 1'b0}
                      + {3'b000, w_dig[2*j+1]};
        end
    end

    assign o_time.valid  = &w_ok;
    assign o_time.hour   = w_pair[0];
    assign o_time.minute = w_pair[1];
    assign o_time.second = w_pair[2];

endmodule

@@ tb/mrte_time_checker.sv @@
// Checker for the meter register time extractor: predicts and compares result transfers.
`timescale 1ns / 100ps

module mrte_time_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port, watched
    input  logic                          i_cfg_we,
    input  logic [mrte_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [mrte_pkg::CfgDataW-1:0] i_cfg_data,
    // input channel, watched
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  mrte_pkg::t_in                 i_in,
    // output channel, watched
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  mrte_pkg::t_out                i_out,
    // status to the testbench top
    output int                            o_fail_count,
    output int                            o_pending
);

    // Configuration copy
    logic [63:0] id_reg;
    logic [3:0]  id_len_reg;

    // Parser copy
    logic [3:0]             match_pos;
    logic                   await_open;
    logic                   capturing;
    logic                   reg_found;
    mrte_pkg::t_value_store value_buf;
    logic [3:0]             value_count;
    logic [6:0]             saved_hour;
    logic [6:0]             saved_minute;
    logic [6:0]             saved_second;

    // Times still owed by the block, oldest first
    mrte_pkg::t_out expected_times[$];
    int             fails = 0;
    int             pending_n = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_n;

    // Effective identifier length, clamped to 1..ID_CHARS
    function automatic logic [3:0] id_chars();
        if (id_len_reg == 4'd0) return 4'd1;
        if (id_len_reg > mrte_pkg::ID_CHARS) return 4'(mrte_pkg::ID_CHARS);
        return id_len_reg;
    endfunction

    function automatic logic [7:0] id_char(input logic [3:0] pos);
        return id_reg[8*pos[2:0] +: 8];
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= mrte_pkg::CH_ZERO) && (c <= mrte_pkg::CH_NINE);
    endfunction

    // Two digits at p and p+1; positions past the captured count are not digits
    function automatic bit read_pair(input int p, output logic [6:0] v);
        v = '0;
        if (p + 1 >= value_count) return 1'b0;
        if (!is_digit(value_buf[p]) || !is_digit(value_buf[p+1])) return 1'b0;
        v = 7'((value_buf[p] - mrte_pkg::CH_ZERO) * 10
               + (value_buf[p+1] - mrte_pkg::CH_ZERO));
        return 1'b1;
    endfunction

    task automatic clear_parse();
        match_pos   = '0;
        await_open  = 1'b0;
        capturing   = 1'b0;
        reg_found   = 1'b0;
        value_count = '0;
    endtask

    // Byte taken as a fresh first identifier character
    task automatic restart_match(input logic [7:0] b);
        match_pos = (b == id_char(4'd0)) ? 4'd1 : 4'd0;
        if (match_pos == id_chars()) begin
            match_pos  = '0;
            await_open = 1'b1;
        end
    endtask

    task automatic scan_byte(input logic [7:0] b);
        if (reg_found) begin
            // register located: capture value until a terminator, drop overflow
            if (capturing) begin
                if (b == mrte_pkg::CH_CLOSE || b == mrte_pkg::CH_STAR) begin
                    capturing = 1'b0;
                end else if (value_count < mrte_pkg::VALUE_CHARS) begin
                    value_buf[value_count[2:0]] = b;
                    value_count++;
                end
            end
        end else if (await_open) begin
            await_open = 1'b0;
            if (b == mrte_pkg::CH_OPEN) begin
                reg_found   = 1'b1;
                capturing   = 1'b1;
                value_count = '0;
            end else begin
                restart_match(b);
            end
        end else if (match_pos < id_chars() && b == id_char(match_pos)) begin
            match_pos++;
            if (match_pos == id_chars()) begin
                match_pos  = '0;
                await_open = 1'b1;
            end
        end else begin
            restart_match(b);
        end
    endtask

    task automatic predict_item(input mrte_pkg::t_in it);
        mrte_pkg::t_out res;
        logic [6:0]     h, m, s;
        case (it.kind)
            mrte_pkg::KIND_BYTE: begin
                scan_byte(it.data_byte);
            end
            mrte_pkg::KIND_DONE, mrte_pkg::KIND_TIMEOUT: begin
                res.time_updated = 1'b0;
                // only a completed reply with a well-formed value moves the time
                if (it.kind == mrte_pkg::KIND_DONE && reg_found && read_pair(0, h)
                        && read_pair(3, m) && read_pair(6, s)) begin
                    saved_hour       = h;
                    saved_minute     = m;
                    saved_second     = s;
                    res.time_updated = 1'b1;
                end
                clear_parse();
                res.hour   = saved_hour;
                res.minute = saved_minute;
                res.second = saved_second;
                expected_times.push_back(res);
            end
            default: begin
                // unused kind: no effect
            end
        endcase
    endtask

    function automatic int field_diff(input string field, input logic [6:0] want,
                                      input logic [6:0] got);
        if (got === want) return 0;
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    task automatic check_result(input mrte_pkg::t_out got);
        mrte_pkg::t_out want;
        if (expected_times.size() == 0) begin
            $display("%0t: result with none expected: %0d:%0d:%0d flag %0d", $time,
                     got.hour, got.minute, got.second, got.time_updated);
            fails++;
        end else begin
            want = expected_times.pop_front();
            fails += field_diff("hour", want.hour, got.hour);
            fails += field_diff("minute", want.minute, got.minute);
            fails += field_diff("second", want.second, got.second);
            fails += field_diff("time_updated", 7'(want.time_updated), 7'(got.time_updated));
        end
    endtask

    // Result checked before the input of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            id_reg       = mrte_pkg::ID_RESET;
            id_len_reg   = mrte_pkg::ID_LEN_RESET;
            clear_parse();
            saved_hour   = '0;
            saved_minute = '0;
            saved_second = '0;
            expected_times.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out);
            if (i_cfg_we) begin
                if (i_cfg_index == mrte_pkg::REG_ID) id_reg = i_cfg_data;
                else if (i_cfg_index == mrte_pkg::REG_ID_LEN) id_len_reg = i_cfg_data[3:0];
            end
            if (i_in_valid && !i_in_stall) predict_item(i_in);
        end
        pending_n = expected_times.size();
    end

endmodule

@@ tb/tb_meter_register_time_extractor_core.sv @@
// Testbench top for the meter register time extractor: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module tb_meter_register_time_extractor_core;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam int         HOLD_CYCLES = 240;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 56;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [mrte_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [mrte_pkg::CfgDataW-1:0] cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    mrte_pkg::t_in                 in_item = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    mrte_pkg::t_out                out_item;
    int                            fail_count;
    int                            pending;

    // Stimulus controls
    bit          in_gaps_on = 1'b1;
    bit          out_gaps_on = 1'b1;
    bit          hold_req = 1'b0;
    int          items_sent = 0;
    logic [63:0] cur_id = mrte_pkg::ID_RESET;
    int          eff_len = mrte_pkg::ID_LEN_RESET;

    always #2 i_clk = ~i_clk;

    meter_register_time_extractor_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    mrte_time_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // One input transfer; valid stays high on return so back-to-back items need no toggle
    task automatic push_item(input logic [1:0] item_kind, input logic [7:0] item_byte);
        if (in_gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{kind: item_kind, data_byte: item_byte};
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    // Sender stops until every owed time has come back, then lets the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Both registers, back to back, while the block is idle
    task automatic set_config(input logic [63:0] id, input logic [3:0] len);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= mrte_pkg::REG_ID;
        cfg_data  <= id;
        @(posedge i_clk);
        cfg_index <= mrte_pkg::REG_ID_LEN;
        cfg_data  <= {junk[63:4], len};
        @(posedge i_clk);
        cfg_we  <= 1'b0;
        cur_id  = id;
        eff_len = (len == 4'd0) ? 1 : (len > mrte_pkg::ID_CHARS) ? mrte_pkg::ID_CHARS
                                                                 : int'(len);
    endtask

    task automatic send_id_prefix(input int n);
        for (int j = 0; j < n; j++) push_item(mrte_pkg::KIND_BYTE, cur_id[8*j +: 8]);
    endtask

    // Value field: mostly HH:MM:SS with random digits, else damaged, short or long
    task automatic send_value();
        logic [7:0] chars [12];
        int         form, n, term;
        form = $urandom_range(0, 9);
        n    = 8;
        for (int i = 0; i < 12; i++) begin
            if (i == 2 || i == 5)
                chars[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_COLON;
            else
                chars[i] = mrte_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        end
        if (form == 7) chars[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
        if (form == 8) n = $urandom_range(0, 7);
        if (form == 9) n = $urandom_range(9, 12);
        for (int i = 0; i < n; i++) push_item(mrte_pkg::KIND_BYTE, chars[i]);
        term = $urandom_range(0, 5);
        if (term == 1) push_item(mrte_pkg::KIND_BYTE, mrte_pkg::CH_STAR);
        else if (term > 1) push_item(mrte_pkg::KIND_BYTE, mrte_pkg::CH_CLOSE);
    endtask

    // One meter reply with noise around the register, ended by complete or timeout
    task automatic send_reply();
        int         shape;
        logic [7:0] b;
        shape = $urandom_range(0, 15);
        repeat ($urandom_range(0, 3))
            push_item(mrte_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
        // partial identifier, then the full one: restart on the mismatching byte
        if (shape == 0 && eff_len > 1) send_id_prefix($urandom_range(1, eff_len - 1));
        // identifier not followed by an opening bracket
        if (shape == 1) begin
            send_id_prefix(eff_len);
            do b = 8'($urandom_range(0, 255)); while (b == mrte_pkg::CH_OPEN);
            push_item(mrte_pkg::KIND_BYTE, b);
        end
        if (shape != 15) begin
            send_id_prefix(eff_len);
            push_item(mrte_pkg::KIND_BYTE, mrte_pkg::CH_OPEN);
            send_value();
            // later occurrence must be ignored
            if ($urandom_range(0, 5) == 0) begin
                send_id_prefix(eff_len);
                push_item(mrte_pkg::KIND_BYTE, mrte_pkg::CH_OPEN);
                send_value();
            end
        end
        repeat ($urandom_range(0, 2))
            push_item(mrte_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) push_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
        push_item(($urandom_range(0, 9) < 8) ? mrte_pkg::KIND_DONE : mrte_pkg::KIND_TIMEOUT,
                  8'($urandom_range(0, 255)));
    endtask

    // Output stall: random bursts, or one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_stall <= 1'b0;
            end else if (out_gaps_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Main stimulus and verdict
    initial begin
        int          phase_end;
        logic [63:0] alpha_id;
        string       msg;
        bit          paused;
        paused = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, a good reply, timeout, unused kind, empty reply
        push_item(mrte_pkg::KIND_BYTE, 8'h00);
        push_item(mrte_pkg::KIND_BYTE, 8'hFF);
        msg = "0.9.1(99:00:59)";
        for (int i = 0; i < msg.len(); i++) push_item(mrte_pkg::KIND_BYTE, msg[i]);
        push_item(mrte_pkg::KIND_DONE, 8'hFF);
        push_item(mrte_pkg::KIND_TIMEOUT, 8'hFF);
        push_item(KIND_UNUSED, 8'hFF);
        push_item(mrte_pkg::KIND_DONE, 8'h00);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1: set_config({$urandom, $urandom}, 4'd1);
                    2: set_config('1, 4'd8);
                    3: set_config('0, 4'd0);
                    4: set_config({$urandom, $urandom}, 4'd15);
                    5: set_config({$urandom, $urandom}, 4'($urandom_range(1, 8)));
                    6: begin
                        // identifier of repeated characters stresses restarts
                        for (int j = 0; j < 8; j++)
                            alpha_id[8*j +: 8] = $urandom_range(0, 1) ? mrte_pkg::CH_ZERO
                                                                      : CH_DOT;
                        set_config(alpha_id, 4'($urandom_range(2, 8)));
                    end
                    default: set_config(mrte_pkg::ID_RESET, mrte_pkg::ID_LEN_RESET);
                endcase
            end
            if (phase == 2) hold_req = 1'b1;
            if (phase == PHASES - 1) begin
                in_gaps_on  = 1'b0;
                out_gaps_on = 1'b0;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                send_reply();
                if (phase == 4 && !paused && items_sent > phase_end - PHASE_ITEMS / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
